>>> sv/aies_pkg.sv
package aies_pkg;

    // Input field widths
    localparam int ETA_W   = 14;
    localparam int PHI_W   = 13;
    localparam int ET_W    = 16;
    localparam int RAD_W   = 22;
    localparam int SUM_W   = 28;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RAD_W;

    // Stream packing
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 2 * VALUE_W;

    // Angular distance arithmetic, units of 1/1024 rad
    localparam int DPHI_W = 12;
    localparam int DETA_W = 14;
    localparam int D2_W   = 29;
    localparam logic [13:0] TWO_PI_FX = 14'd6434;
    localparam logic [13:0] PI_FX     = 14'd3217;

    // Sum saturation
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Ratio division: (sum << 16) / cluster Et
    localparam int FRAC_W    = 16;
    localparam int DVD_W     = SUM_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Queue between the front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Item kinds
    localparam logic KIND_CLUSTER = 1'b0;
    localparam logic KIND_TOWER   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS_SQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_MODE   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_ET = 2'd2;

    // Classified item handed from front to back
    typedef struct packed {
        logic            kind;
        logic            hit;
        logic            last;
        logic [ET_W-1:0] had_et;
        logic [ET_W-1:0] em_et;
        logic [ET_W-1:0] cluster_et;
    } t_qitem;

endpackage

>>> sv/annulus_isolation_energy_sum_core.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: eta, phi, had_et, em_et, cluster_et;
//                                               tuser: kind; tlast: last
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: had_value, em_value; tuser: status
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Tower and cluster transactions enter one per cycle while the queue has room; the
// front pipeline registers distances, then squares, before the queue. An item with
// tlast takes the back end through prepare and emit, plus divide in relative mode
// with nonzero cluster Et (bit-serial ratio dividers, one quotient bit a cycle over
// 44 bits, both sums in parallel). Reset is synchronous and active low and clears
// configuration, sums and control. s_axis_tready drops only when the queue is full;
// a stalled result waits in the output register while the front keeps accepting.
module annulus_isolation_energy_sum_core #(
    parameter int QUEUE_DEPTH = aies_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [13:0] eta, [26:14] phi, [42:27] had_et, [58:43] em_et, [74:59] cluster_et,
    // [79:75] zero
    input  logic [aies_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    // [0] kind
    input  logic                                s_axis_tuser,
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] had_value, [63:32] em_value
    output logic [aies_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [aies_pkg::STAT_W-1:0]         m_axis_tuser,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aies_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [aies_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [aies_pkg::RAD_W-1:0]   r_inner_radius_sq;
    logic [aies_pkg::RAD_W-1:0]   r_outer_radius_sq;
    logic                         r_relative_mode;

    logic                         q_push;
    logic                         q_full;
    logic                         q_pop;
    logic                         q_empty;
    aies_pkg::t_qitem             q_in;
    aies_pkg::t_qitem             q_out;
    logic [aies_pkg::VALUE_W-1:0] had_value;
    logic [aies_pkg::VALUE_W-1:0] em_value;

    // Registers are always writable; an unknown index is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_radius_sq <= '0;
            r_outer_radius_sq <= '0;
            r_relative_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aies_pkg::CFG_INNER_RADIUS_SQ: r_inner_radius_sq <= i_cfg_data;
                aies_pkg::CFG_OUTER_RADIUS_SQ: r_outer_radius_sq <= i_cfg_data;
                aies_pkg::CFG_RELATIVE_MODE:   r_relative_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front: compute distances and classify each tower against the annulus.
    aies_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_kind            (s_axis_tuser),
        .i_last            (s_axis_tlast),
        .i_eta             (s_axis_tdata[13:0]),
        .i_phi             (s_axis_tdata[26:14]),
        .i_had_et          (s_axis_tdata[42:27]),
        .i_em_et           (s_axis_tdata[58:43]),
        .i_cluster_et      (s_axis_tdata[74:59]),
        .i_inner_radius_sq (r_inner_radius_sq),
        .i_outer_radius_sq (r_outer_radius_sq),
        .o_push            (q_push),
        .o_item            (q_in),
        .i_q_full          (q_full)
    );

    // Queue: decouple the classify pipeline from the accumulate/divide back end.
    aies_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    // Back: accumulate sums, form ratios, hold the result for the master side.
    aies_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (q_out),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .i_relative_mode (r_relative_mode),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_had_value     (had_value),
        .o_em_value      (em_value),
        .o_status        (m_axis_tuser)
    );

    assign m_axis_tdata = {em_value, had_value};

endmodule

>>> sv/aies_front.sv
module aies_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic                          i_last,
    input  logic [aies_pkg::ETA_W-1:0]    i_eta,
    input  logic [aies_pkg::PHI_W-1:0]    i_phi,
    input  logic [aies_pkg::ET_W-1:0]     i_had_et,
    input  logic [aies_pkg::ET_W-1:0]     i_em_et,
    input  logic [aies_pkg::ET_W-1:0]     i_cluster_et,
    input  logic [aies_pkg::RAD_W-1:0]    i_inner_radius_sq,
    input  logic [aies_pkg::RAD_W-1:0]    i_outer_radius_sq,
    output logic                          o_push,
    output aies_pkg::t_qitem              o_item,
    input  logic                          i_q_full
);

    logic [aies_pkg::ETA_W-1:0]    r_clu_eta;
    logic [aies_pkg::PHI_W-1:0]    r_clu_phi;

    // stage 1: absolute distances
    logic                          r_v1;
    aies_pkg::t_qitem              r_it1;
    logic [aies_pkg::DETA_W-1:0]   r_deta;
    logic [aies_pkg::DPHI_W-1:0]   r_dphi;

    // stage 2: squares
    logic                          r_v2;
    aies_pkg::t_qitem              r_it2;
    logic [2*aies_pkg::DETA_W-1:0] r_sq_eta;
    logic [2*aies_pkg::DPHI_W-1:0] r_sq_phi;

    logic                          advance;
    logic                          accept;
    logic [13:0]                   phi_ext;
    logic [13:0]                   phi_w14;
    logic [aies_pkg::PHI_W-1:0]    phi_w;
    logic [13:0]                   dphi_s;
    logic [13:0]                   dphi_a;
    logic [13:0]                   dphi_b;
    logic [13:0]                   dphi_c;
    logic [14:0]                   deta_s;
    logic [14:0]                   deta_a;
    logic [aies_pkg::D2_W-1:0]     d2;

    assign advance = !r_v2 || !i_q_full;
    assign o_ready = advance;
    assign accept  = i_valid && advance;

    always_comb begin
        // wrap phi into 0..2pi
        phi_ext = {i_phi[aies_pkg::PHI_W-1], i_phi};
        phi_w14 = i_phi[aies_pkg::PHI_W-1] ? phi_ext + aies_pkg::TWO_PI_FX : phi_ext;
        phi_w   = phi_w14[aies_pkg::PHI_W-1:0];
        // minimal azimuthal distance
        dphi_s  = {1'b0, phi_w} - {1'b0, r_clu_phi};
        dphi_a  = dphi_s[13] ? (~dphi_s + 14'd1) : dphi_s;
        dphi_b  = (dphi_a > aies_pkg::TWO_PI_FX) ? dphi_a - aies_pkg::TWO_PI_FX : dphi_a;
        dphi_c  = (dphi_b > aies_pkg::PI_FX) ? aies_pkg::TWO_PI_FX - dphi_b : dphi_b;
        // eta distance
        deta_s  = {i_eta[aies_pkg::ETA_W-1], i_eta} - {r_clu_eta[aies_pkg::ETA_W-1], r_clu_eta};
        deta_a  = deta_s[14] ? (~deta_s + 15'd1) : deta_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clu_eta <= '0;
            r_clu_phi <= '0;
        end else if (accept && i_kind == aies_pkg::KIND_CLUSTER) begin
            r_clu_eta <= i_eta;
            r_clu_phi <= phi_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (advance) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_it1.kind       <= i_kind;
            r_it1.hit        <= 1'b0;
            r_it1.last       <= i_last;
            r_it1.had_et     <= i_had_et;
            r_it1.em_et      <= i_em_et;
            r_it1.cluster_et <= i_cluster_et;
            r_deta           <= deta_a[aies_pkg::DETA_W-1:0];
            r_dphi           <= dphi_c[aies_pkg::DPHI_W-1:0];
            r_it2            <= r_it1;
            r_sq_eta         <= r_deta * r_deta;
            r_sq_phi         <= r_dphi * r_dphi;
        end
    end

    // annulus test: inner^2 <= d^2 < outer^2
    assign d2 = {1'b0, r_sq_eta} + {5'b0, r_sq_phi};

    always_comb begin
        o_item     = r_it2;
        o_item.hit = (d2 < {7'b0, i_outer_radius_sq}) && (d2 >= {7'b0, i_inner_radius_sq});
    end

    assign o_push = r_v2 && !i_q_full;

endmodule

>>> sv/aies_fifo.sv
module aies_fifo #(
    parameter int DEPTH = aies_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  aies_pkg::t_qitem i_item,
    output logic             o_full,
    input  logic             i_pop,
    output aies_pkg::t_qitem o_item,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    aies_pkg::t_qitem r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/aies_div.sv
module aies_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [aies_pkg::SUM_W-1:0]   i_sum,
    input  logic [aies_pkg::ET_W-1:0]    i_den,
    output logic                         o_done,
    output logic [aies_pkg::VALUE_W-1:0] o_quot,
    output logic                         o_sat
);

    // restoring division, one quotient bit per cycle
    logic                             r_busy;
    logic [aies_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [aies_pkg::DVD_W-1:0]       r_dvd;
    logic [aies_pkg::ET_W-1:0]        r_rem;
    logic [aies_pkg::ET_W-1:0]        r_den;
    logic [aies_pkg::ET_W:0]          rem_sh;
    logic [aies_pkg::ET_W:0]          rem_sub;
    logic                             q_bit;

    assign rem_sh  = {r_rem, r_dvd[aies_pkg::DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= aies_pkg::DIV_CNT_W'(aies_pkg::DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_sum, {aies_pkg::FRAC_W{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            r_dvd <= {r_dvd[aies_pkg::DVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[aies_pkg::ET_W-1:0] : rem_sh[aies_pkg::ET_W-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_dvd[aies_pkg::VALUE_W-1:0];
    assign o_sat  = |r_dvd[aies_pkg::DVD_W-1:aies_pkg::VALUE_W];

endmodule

>>> sv/aies_back.sv
module aies_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  aies_pkg::t_qitem                i_item,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  logic                            i_relative_mode,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [aies_pkg::VALUE_W-1:0]    o_had_value,
    output logic [aies_pkg::VALUE_W-1:0]    o_em_value,
    output logic [aies_pkg::STAT_W-1:0]     o_status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [aies_pkg::ET_W-1:0]       r_cet;
    logic [aies_pkg::SUM_W-1:0]      r_had_sum;
    logic [aies_pkg::SUM_W-1:0]      r_em_sum;
    logic                            r_ovf;
    logic [aies_pkg::VALUE_W-1:0]    r_res_had;
    logic [aies_pkg::VALUE_W-1:0]    r_res_em;
    logic [aies_pkg::STAT_W-1:0]     r_res_stat;
    logic                            r_out_valid;
    logic [aies_pkg::VALUE_W-1:0]    r_out_had;
    logic [aies_pkg::VALUE_W-1:0]    r_out_em;
    logic [aies_pkg::STAT_W-1:0]     r_out_stat;

    logic                            div_start;
    logic                            had_done;
    logic                            em_done;
    logic [aies_pkg::VALUE_W-1:0]    had_quot;
    logic [aies_pkg::VALUE_W-1:0]    em_quot;
    logic                            had_sat;
    logic                            em_sat;
    logic                            out_free;
    logic                            use_div;
    logic [aies_pkg::SUM_W:0]        had_add;
    logic [aies_pkg::SUM_W:0]        em_add;

    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign use_div   = i_relative_mode && (r_cet != '0);
    assign div_start = (r_state == ST_PREP) && use_div;
    assign out_free  = !r_out_valid || i_ready;
    assign had_add   = {1'b0, r_had_sum} + {13'b0, i_item.had_et};
    assign em_add    = {1'b0, r_em_sum} + {13'b0, i_item.em_et};

    aies_div u_div_had (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_had_sum),
        .i_den   (r_cet),
        .o_done  (had_done),
        .o_quot  (had_quot),
        .o_sat   (had_sat)
    );

    aies_div u_div_em (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_em_sum),
        .i_den   (r_cet),
        .o_done  (em_done),
        .o_quot  (em_quot),
        .o_sat   (em_sat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_item.last) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = use_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (had_done && em_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cet     <= '0;
            r_had_sum <= '0;
            r_em_sum  <= '0;
            r_ovf     <= 1'b0;
        end else if (o_pop) begin
            if (i_item.kind == aies_pkg::KIND_CLUSTER) begin
                r_cet     <= i_item.cluster_et;
                r_had_sum <= '0;
                r_em_sum  <= '0;
                r_ovf     <= 1'b0;
            end else if (i_item.hit) begin
                if (had_add[aies_pkg::SUM_W]) begin
                    r_had_sum <= aies_pkg::SUM_MAX;
                end else begin
                    r_had_sum <= had_add[aies_pkg::SUM_W-1:0];
                end
                if (em_add[aies_pkg::SUM_W]) begin
                    r_em_sum <= aies_pkg::SUM_MAX;
                end else begin
                    r_em_sum <= em_add[aies_pkg::SUM_W-1:0];
                end
                if (had_add[aies_pkg::SUM_W] || em_add[aies_pkg::SUM_W]) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP && !use_div) begin
            if (i_relative_mode) begin
                r_res_had  <= '0;
                r_res_em   <= '0;
                r_res_stat <= aies_pkg::STAT_ZERO_ET;
            end else begin
                r_res_had  <= {4'b0, r_had_sum};
                r_res_em   <= {4'b0, r_em_sum};
                r_res_stat <= r_ovf ? aies_pkg::STAT_SAT : aies_pkg::STAT_OK;
            end
        end else if (r_state == ST_DIV && had_done && em_done) begin
            r_res_had  <= had_sat ? {aies_pkg::VALUE_W{1'b1}} : had_quot;
            r_res_em   <= em_sat ? {aies_pkg::VALUE_W{1'b1}} : em_quot;
            r_res_stat <= (r_ovf || had_sat || em_sat) ? aies_pkg::STAT_SAT : aies_pkg::STAT_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_out_had  <= r_res_had;
            r_out_em   <= r_res_em;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_had_value = r_out_had;
    assign o_em_value  = r_out_em;
    assign o_status    = r_out_stat;

endmodule
